### design/delay_ecn_congestion_window_macros.svh
// assertion helpers shared by the checker
`ifndef DELAY_ECN_CONGESTION_WINDOW_MACROS_SVH
`define DELAY_ECN_CONGESTION_WINDOW_MACROS_SVH

// same-cycle implication
`define DECW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decw assertion failed");

// next-cycle implication
`define DECW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decw assertion failed");

`endif

### design/decw_pkg.sv
`timescale 1ns / 1ps
package decw_pkg;

  localparam int unsigned NUM_W  = 48;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned CNT_W  = 6;

  localparam logic [31:0] RST_PATH_BDP = 32'd150000;

  localparam logic [2:0] REG_SEG_SIZE        = 3'd0;
  localparam logic [2:0] REG_TARGET_RTT      = 3'd1;
  localparam logic [2:0] REG_BASE_RTT        = 3'd2;
  localparam logic [2:0] REG_PATH_BDP        = 3'd3;
  localparam logic [2:0] REG_QA_SCALE        = 3'd4;
  localparam logic [2:0] REG_FAIR_GAIN       = 3'd5;
  localparam logic [2:0] REG_DELAY_INC_GAIN  = 3'd6;
  localparam logic [2:0] REG_WINDOW_DEC_GAIN = 3'd7;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_NACK    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    MS_QA, MS_TOL, MS_DLY, MS_MM, MS_MMX, MS_T2T1, MS_T1R, MS_T2R,
    MS_DEC, MS_WZ, MS_T1M, MS_T2M
  } mul_sel_t;

  typedef enum logic [1:0] {
    DEN_RTT, DEN_WIN, DEN_BDP
  } den_sel_t;

  typedef enum logic [4:0] {
    WB_NONE, WB_LOAD, WB_PRE, WB_QA, WB_FAST, WB_T1_Q_M8, WB_T2_Q, WB_T1_P8_M,
    WB_ADD_P8, WB_ADD_P16, WB_T1_Q_256, WB_T2_Q_256, WB_T1_PROD, WB_T1_SUM,
    WB_SUB_P16, WB_T2_Q_SAT, WB_T1_P8, WB_SUB_D
  } wb_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    den_sel_t div_den;
    wb_sel_t  wb;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ignoring;
    logic       adapted;
    logic       fast_on;
    logic       ecn;
    logic       rtt_lt;
    logic       rtt_gt;
    logic       div_done;
  } dp_status_t;

  // clamp to [max(seg,1), 2^32-1]
  function automatic logic [31:0] win_clamp(input logic [48:0] v, input logic [15:0] seg);
    logic [31:0] lo;
    lo = (seg == 16'd0) ? 32'd1 : {16'd0, seg};
    if (v < {17'd0, lo}) return lo;
    else if (v > 49'h0_FFFF_FFFF) return 32'hFFFF_FFFF;
    else return v[31:0];
  endfunction

endpackage

### design/decw_div.sv
`timescale 1ns / 1ps
module decw_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [decw_pkg::NUM_W-1:0]     num,
  input  logic [decw_pkg::DEN_W-1:0]     den,
  output logic [decw_pkg::NUM_W-1:0]     quot,
  output logic                           done
);

  logic                          busy;
  logic [decw_pkg::CNT_W-1:0]    cnt;
  logic [decw_pkg::DEN_W-1:0]    rem;
  logic [decw_pkg::DEN_W-1:0]    divisor;
  logic [decw_pkg::DEN_W:0]      trial;
  logic                          fits;

  assign trial = {rem, quot[decw_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quot    <= num;
        divisor <= den;
      end else if (busy) begin
        rem  <= fits ? decw_pkg::DEN_W'(trial - {1'b0, divisor})
                     : trial[decw_pkg::DEN_W-1:0];
        quot <= {quot[decw_pkg::NUM_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == decw_pkg::CNT_W'(decw_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/decw_dpath.sv
`timescale 1ns / 1ps
module decw_dpath #(
  parameter int unsigned DEC_GAIN_W     = 256,
  parameter int unsigned REACT_SCALE    = 256,
  parameter int unsigned FAST_TOLERANCE = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [1:0]           in_kind,
  input  logic                 in_ecn,
  input  logic [31:0]          in_rtt,
  input  logic [47:0]          in_now,
  input  decw_pkg::dp_cmd_t    cmd,
  output decw_pkg::dp_status_t status,
  output logic [31:0]          window_bytes,
  output logic                 adapted,
  output logic                 fast_mode
);

  localparam logic [15:0] DEC_G = 16'(DEC_GAIN_W);
  localparam logic [15:0] REACT = 16'(REACT_SCALE);
  localparam logic [8:0]  TOL   = 9'(FAST_TOLERANCE);

  logic [15:0] seg_size, qa_scale, fair_gain, delay_inc_gain, window_dec_gain;
  logic [31:0] target_rtt, base_rtt, path_bdp;

  logic [31:0] window, acked_count, ignore_target, ignored_count, fast_bytes;
  logic [47:0] adapt_deadline;
  logic        adapt_pending, fast_on, adapted_flag;

  logic [1:0]  ev_kind;
  logic        ev_ecn;
  logic [31:0] ev_rtt;
  logic [47:0] ev_now;

  logic [47:0] t1, t2;
  logic [71:0] prod;
  logic [47:0] mul_a;
  logic [23:0] mul_b;
  logic [31:0] den;
  logic [47:0] div_q;
  logic        div_done;

  logic        ignoring;
  logic [31:0] rtt_diff;
  logic [23:0] seg_x256;
  logic [31:0] fb_sum;
  logic        fast_cond;
  logic [48:0] t1_sum;
  logic [47:0] d_val;
  logic [47:0] d_dec;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [48:0] add_clip(input logic [31:0] w, input logic [47:0] inc);
    logic [31:0] c;
    c = (inc > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : inc[31:0];
    return {17'd0, w} + {17'd0, c};
  endfunction

  function automatic logic [48:0] sub_floor(input logic [31:0] w, input logic [47:0] dec);
    logic [31:0] r;
    r = w - dec[31:0];
    return (dec >= {16'd0, w}) ? 49'd0 : {17'd0, r};
  endfunction

  decw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod[47:0]),
    .den   (den),
    .quot  (div_q),
    .done  (div_done)
  );

  assign ignoring  = ignored_count < ignore_target;
  assign rtt_diff  = (ev_rtt > base_rtt) ? ev_rtt - base_rtt : base_rtt - ev_rtt;
  assign seg_x256  = {seg_size, 8'd0};
  assign fb_sum    = sat_add32(fast_bytes, {16'd0, seg_size});
  assign fast_cond = !ev_ecn && ({32'd0, rtt_diff, 8'd0} < prod);
  assign t1_sum    = {1'b0, t1} + {1'b0, prod[47:0]};
  assign d_val     = prod[55:8];
  assign d_dec     = (d_val > {32'd0, seg_size}) ? d_val : {32'd0, seg_size};

  assign status.kind     = ev_kind;
  assign status.ignoring = ignoring;
  assign status.adapted  = adapted_flag;
  assign status.fast_on  = fast_on;
  assign status.ecn      = ev_ecn;
  assign status.rtt_lt   = ev_rtt < target_rtt;
  assign status.rtt_gt   = ev_rtt > target_rtt;
  assign status.div_done = div_done;

  always_comb begin
    unique case (cmd.mul_sel)
      decw_pkg::MS_QA:   begin mul_a = {16'd0, acked_count};           mul_b = {8'd0, qa_scale}; end
      decw_pkg::MS_TOL:  begin mul_a = {16'd0, base_rtt};              mul_b = {15'd0, TOL}; end
      decw_pkg::MS_DLY:  begin mul_a = {16'd0, target_rtt - ev_rtt};  mul_b = {8'd0, delay_inc_gain}; end
      decw_pkg::MS_MM:   begin mul_a = {32'd0, seg_size};              mul_b = {8'd0, seg_size}; end
      decw_pkg::MS_MMX:  begin mul_a = {16'd0, prod[31:0]};            mul_b = {8'd0, fair_gain}; end
      decw_pkg::MS_T2T1: begin mul_a = t2;                             mul_b = t1[23:0]; end
      decw_pkg::MS_T1R:  begin mul_a = t1;                             mul_b = {8'd0, REACT}; end
      decw_pkg::MS_T2R:  begin mul_a = t2;                             mul_b = {8'd0, REACT}; end
      decw_pkg::MS_DEC:  begin mul_a = {16'd0, ev_rtt - target_rtt};  mul_b = {8'd0, DEC_G}; end
      decw_pkg::MS_WZ:   begin mul_a = {16'd0, window};                mul_b = {8'd0, window_dec_gain}; end
      decw_pkg::MS_T1M:  begin mul_a = t1;                             mul_b = {8'd0, seg_size}; end
      decw_pkg::MS_T2M:  begin mul_a = t2;                             mul_b = {8'd0, seg_size}; end
      default:           begin mul_a = '0;                             mul_b = '0; end
    endcase
  end

  always_comb begin
    unique case (cmd.div_den)
      decw_pkg::DEN_RTT: den = (ev_rtt == 32'd0) ? 32'd1 : ev_rtt;
      decw_pkg::DEN_BDP: den = (path_bdp == 32'd0) ? 32'd1 : path_bdp;
      default:           den = window;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size        <= 16'd4096;
      target_rtt      <= 32'd12000;
      base_rtt        <= 32'd10000;
      path_bdp        <= decw_pkg::RST_PATH_BDP;
      qa_scale        <= 16'd256;
      fair_gain       <= 16'd256;
      delay_inc_gain  <= 16'd256;
      window_dec_gain <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        decw_pkg::REG_SEG_SIZE:        seg_size        <= cfg_data[15:0];
        decw_pkg::REG_TARGET_RTT:      target_rtt      <= cfg_data;
        decw_pkg::REG_BASE_RTT:        base_rtt        <= cfg_data;
        decw_pkg::REG_PATH_BDP:        path_bdp        <= cfg_data;
        decw_pkg::REG_QA_SCALE:        qa_scale        <= cfg_data[15:0];
        decw_pkg::REG_FAIR_GAIN:       fair_gain       <= cfg_data[15:0];
        decw_pkg::REG_DELAY_INC_GAIN:  delay_inc_gain  <= cfg_data[15:0];
        decw_pkg::REG_WINDOW_DEC_GAIN: window_dec_gain <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= {24'd0, mul_a} * {48'd0, mul_b};
    if (cmd.out_load) begin
      window_bytes <= window;
      adapted      <= adapted_flag;
      fast_mode    <= fast_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= decw_pkg::RST_PATH_BDP;
      acked_count    <= '0;
      ignore_target  <= '0;
      ignored_count  <= '0;
      adapt_deadline <= '0;
      adapt_pending  <= 1'b0;
      fast_bytes     <= '0;
      fast_on        <= 1'b0;
      adapted_flag   <= 1'b0;
    end else begin
      unique case (cmd.wb)
        decw_pkg::WB_LOAD: begin
          ev_kind      <= in_kind;
          ev_ecn       <= in_ecn;
          ev_rtt       <= in_rtt;
          ev_now       <= in_now;
          adapted_flag <= 1'b0;
        end
        decw_pkg::WB_PRE: begin
          if (ev_kind == decw_pkg::KIND_ACK) begin
            acked_count <= sat_add32(acked_count, {16'd0, seg_size});
            if (ignoring) ignored_count <= sat_add32(ignored_count, {16'd0, seg_size});
          end else if (ev_kind == decw_pkg::KIND_NACK || ev_kind == decw_pkg::KIND_TIMEOUT) begin
            if (!ignoring) adapt_pending <= 1'b1;
          end
        end
        decw_pkg::WB_QA: begin
          if (ev_now >= adapt_deadline) begin
            if (adapt_deadline != 48'd0 && adapt_pending) begin
              adapt_pending <= 1'b0;
              adapted_flag  <= 1'b1;
              ignore_target <= window;
              window        <= decw_pkg::win_clamp({9'd0, prod[47:8]}, seg_size);
              ignored_count <= '0;
            end
            acked_count    <= '0;
            adapt_deadline <= ev_now + {16'd0, target_rtt};
          end
        end
        decw_pkg::WB_FAST: begin
          if (fast_cond) begin
            fast_bytes <= fb_sum;
            if (fb_sum > window || fast_on) begin
              window  <= decw_pkg::win_clamp(add_clip(window, {32'd0, seg_size}), seg_size);
              fast_on <= 1'b1;
            end
          end else begin
            fast_bytes <= '0;
            fast_on    <= 1'b0;
          end
        end
        decw_pkg::WB_T1_Q_M8:
          t1 <= (div_q > {24'd0, seg_x256}) ? {24'd0, seg_x256} : div_q;
        decw_pkg::WB_T2_Q:
          t2 <= div_q;
        decw_pkg::WB_T1_P8_M:
          t1 <= (prod[71:8] > {48'd0, seg_size}) ? {32'd0, seg_size} : prod[55:8];
        decw_pkg::WB_ADD_P8:
          window <= decw_pkg::win_clamp(add_clip(window, prod[55:8]), seg_size);
        decw_pkg::WB_ADD_P16:
          window <= decw_pkg::win_clamp(add_clip(window, prod[63:16]), seg_size);
        decw_pkg::WB_T1_Q_256:
          t1 <= (div_q > 48'd256) ? 48'd256 : div_q;
        decw_pkg::WB_T2_Q_256:
          t2 <= (div_q > 48'd256) ? 48'd256 : div_q;
        decw_pkg::WB_T1_PROD:
          t1 <= prod[47:0];
        decw_pkg::WB_T1_SUM:
          t1 <= (t1_sum > {25'd0, seg_x256}) ? {24'd0, seg_x256} : t1_sum[47:0];
        decw_pkg::WB_SUB_P16:
          window <= decw_pkg::win_clamp(sub_floor(window, prod[63:16]), seg_size);
        decw_pkg::WB_T2_Q_SAT:
          t2 <= (div_q > 48'h0000_FFFF_FFFF) ? 48'h0000_FFFF_FFFF : div_q;
        decw_pkg::WB_T1_P8:
          t1 <= prod[55:8];
        decw_pkg::WB_SUB_D:
          window <= decw_pkg::win_clamp(sub_floor(window, d_dec), seg_size);
        default: ;
      endcase
    end
  end

endmodule

### design/decw_ctrl.sv
`timescale 1ns / 1ps
module decw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  decw_pkg::dp_status_t status,
  output decw_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_PRE, S_QA_MUL, S_QA_APPLY, S_QA_NEXT, S_FAST_MUL, S_FAST_APPLY,
    S_CORE_SEL,
    C1_M1, C1_D1, C1_W1, C1_M2, C1_D2, C1_W2, C1_M3, C1_CL, C1_M4, C1_ADD,
    F_M1, F_M2, F_D, F_W, F_M3, F_ADD,
    C2_M1, C2_D1, C2_W1, C2_M2, C2_D2, C2_W2, C2_M3, C2_S1, C2_M4, C2_S2,
    C2_M5, C2_SUB,
    C3_M1, C3_D, C3_W, C3_M2, C3_S, C3_M3, C3_SUB,
    S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = decw_pkg::MS_QA;
    cmd.div_start = 1'b0;
    cmd.div_den   = decw_pkg::DEN_RTT;
    cmd.wb        = decw_pkg::WB_NONE;
    cmd.out_load  = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.wb     = decw_pkg::WB_LOAD;
        state_next = S_PRE;
      end
      S_PRE: begin
        cmd.wb     = decw_pkg::WB_PRE;
        state_next = (status.kind != decw_pkg::KIND_UNUSED && !status.ignoring)
                     ? S_QA_MUL : S_FIN;
      end
      S_QA_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_QA; state_next = S_QA_APPLY;
      end
      S_QA_APPLY: begin cmd.wb = decw_pkg::WB_QA; state_next = S_QA_NEXT; end
      S_QA_NEXT:
        state_next = (status.adapted || status.kind != decw_pkg::KIND_ACK)
                     ? S_FIN : S_FAST_MUL;
      S_FAST_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_TOL; state_next = S_FAST_APPLY;
      end
      S_FAST_APPLY: begin cmd.wb = decw_pkg::WB_FAST; state_next = S_CORE_SEL; end
      S_CORE_SEL: begin
        priority if (status.fast_on)                  state_next = S_FIN;
        else if (!status.ecn && status.rtt_lt)        state_next = C1_M1;
        else if (status.ecn && status.rtt_gt)         state_next = C2_M1;
        else if (status.ecn && status.rtt_lt)         state_next = C3_M1;
        else if (!status.ecn && status.rtt_gt)        state_next = F_M1;
        else                                          state_next = S_FIN;
      end
      // rtt below target, no mark
      C1_M1: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_DLY; state_next = C1_D1; end
      C1_D1: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_RTT; state_next = C1_W1; end
      C1_W1: if (status.div_done) begin cmd.wb = decw_pkg::WB_T1_Q_M8; state_next = C1_M2; end
      C1_M2: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_MM; state_next = C1_D2; end
      C1_D2: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_WIN; state_next = C1_W2; end
      C1_W2: if (status.div_done) begin cmd.wb = decw_pkg::WB_T2_Q; state_next = C1_M3; end
      C1_M3: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T2T1; state_next = C1_CL; end
      C1_CL: begin cmd.wb = decw_pkg::WB_T1_P8_M; state_next = C1_M4; end
      C1_M4: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T1R; state_next = C1_ADD; end
      C1_ADD: begin cmd.wb = decw_pkg::WB_ADD_P8; state_next = F_M1; end
      // fairness increase
      F_M1: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_MM; state_next = F_M2; end
      F_M2: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_MMX; state_next = F_D; end
      F_D: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_WIN; state_next = F_W; end
      F_W: if (status.div_done) begin cmd.wb = decw_pkg::WB_T2_Q; state_next = F_M3; end
      F_M3: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T2R; state_next = F_ADD; end
      F_ADD: begin cmd.wb = decw_pkg::WB_ADD_P16; state_next = S_FIN; end
      // rtt above target, marked
      C2_M1: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_DEC; state_next = C2_D1; end
      C2_D1: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_RTT; state_next = C2_W1; end
      C2_W1: if (status.div_done) begin cmd.wb = decw_pkg::WB_T1_Q_256; state_next = C2_M2; end
      C2_M2: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_WZ; state_next = C2_D2; end
      C2_D2: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_BDP; state_next = C2_W2; end
      C2_W2: if (status.div_done) begin cmd.wb = decw_pkg::WB_T2_Q_256; state_next = C2_M3; end
      C2_M3: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T1M; state_next = C2_S1; end
      C2_S1: begin cmd.wb = decw_pkg::WB_T1_PROD; state_next = C2_M4; end
      C2_M4: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T2M; state_next = C2_S2; end
      C2_S2: begin cmd.wb = decw_pkg::WB_T1_SUM; state_next = C2_M5; end
      C2_M5: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T1R; state_next = C2_SUB; end
      C2_SUB: begin cmd.wb = decw_pkg::WB_SUB_P16; state_next = S_FIN; end
      // rtt below target, marked
      C3_M1: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_WZ; state_next = C3_D; end
      C3_D: begin cmd.div_start = 1'b1; cmd.div_den = decw_pkg::DEN_BDP; state_next = C3_W; end
      C3_W: if (status.div_done) begin cmd.wb = decw_pkg::WB_T2_Q_SAT; state_next = C3_M2; end
      C3_M2: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T2M; state_next = C3_S; end
      C3_S: begin cmd.wb = decw_pkg::WB_T1_P8; state_next = C3_M3; end
      C3_M3: begin cmd.mul_en = 1'b1; cmd.mul_sel = decw_pkg::MS_T1R; state_next = C3_SUB; end
      C3_SUB: begin cmd.wb = decw_pkg::WB_SUB_D; state_next = S_FIN; end
      S_FIN: if (!out_valid || out_ready) begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### design/delay_ecn_congestion_window.sv
// an accepted transaction reaches out_valid via S_PRE and S_FIN if it is ignored or unused,
// a loss event or quick adapt also passes the quick adapt states, fast increase or no window
// case also the fast check and S_CORE_SEL; a window case adds one to three serial divisions
// throughput: one transaction at a time, the next taken the cycle after the result loads
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous, loads register defaults and a window of 150000, no clearing pass
`timescale 1ns / 1ps
module delay_ecn_congestion_window #(
  parameter int unsigned DEC_GAIN_W     = 256,
  parameter int unsigned REACT_SCALE    = 256,
  parameter int unsigned FAST_TOLERANCE = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic        ecn_marked,
  input  logic [31:0] rtt_ns,
  input  logic [47:0] now_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] window_bytes,
  output logic        adapted,
  output logic        fast_mode
);

  decw_pkg::dp_cmd_t    cmd;
  decw_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  decw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  decw_dpath #(
    .DEC_GAIN_W     (DEC_GAIN_W),
    .REACT_SCALE    (REACT_SCALE),
    .FAST_TOLERANCE (FAST_TOLERANCE)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (kind),
    .in_ecn       (ecn_marked),
    .in_rtt       (rtt_ns),
    .in_now       (now_ns),
    .cmd          (cmd),
    .status       (status),
    .window_bytes (window_bytes),
    .adapted      (adapted),
    .fast_mode    (fast_mode)
  );

endmodule

### design/decw_checker.sv
`timescale 1ns / 1ps
`include "delay_ecn_congestion_window_macros.svh"
module decw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] window_bytes,
  input logic        adapted,
  input logic        fast_mode
);

  `DECW_ASSERT_SAME(a_window_nonzero, clk, rst, out_valid, window_bytes != 32'd0)
  `DECW_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `DECW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(window_bytes) && $stable(adapted) && $stable(fast_mode))

endmodule

bind delay_ecn_congestion_window decw_checker u_decw_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned DEC_GAIN_W     = 256;
  localparam int unsigned REACT_SCALE    = 256;
  localparam int unsigned FAST_TOLERANCE = 13;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned PHASE_EVENTS = 220;

  typedef struct {
    logic [1:0]  kind;
    logic        ecn;
    logic [31:0] rtt;
    logic [47:0] now;
  } cc_event_t;

  typedef struct {
    logic [31:0] win;
    logic        adapted;
    logic        fast;
  } window_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = decw_pkg::REG_SEG_SIZE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = decw_pkg::KIND_ACK;
  logic        ecn_marked = 1'b0;
  logic [31:0] rtt_ns = '0;
  logic [47:0] now_ns = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] window_bytes;
  logic        adapted;
  logic        fast_mode;

  delay_ecn_congestion_window #(
    .DEC_GAIN_W(DEC_GAIN_W),
    .REACT_SCALE(REACT_SCALE),
    .FAST_TOLERANCE(FAST_TOLERANCE)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .ecn_marked(ecn_marked),
    .rtt_ns(rtt_ns), .now_ns(now_ns),
    .out_valid(out_valid), .out_ready(out_ready), .window_bytes(window_bytes),
    .adapted(adapted), .fast_mode(fast_mode)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor copy of registers and state
  logic [63:0] r_seg, r_target, r_base, r_bdp, r_qa, r_fair, r_inc, r_dec;
  logic [63:0] s_win, s_acked, s_ign_target, s_ignored, s_deadline, s_fast_bytes;
  logic        s_pending, s_fast;

  cc_event_t event_queue[$];
  window_t   expected_windows[$];
  cc_event_t on_wire;
  int unsigned send_idle = 8, recv_idle = 60;
  int unsigned errors = 0, cycles = 0, n_results = 0, n_adapted = 0, n_fast = 0;
  logic [47:0] gen_now = '0;

  function automatic logic [63:0] win_floor();
    return (r_seg != 0) ? r_seg : 64'd1;
  endfunction

  function automatic void set_win(logic [63:0] v);
    if (v < win_floor()) v = win_floor();
    if (v > M32) v = M32;
    s_win = v;
  endfunction

  function automatic void grow_win(logic [63:0] inc);
    set_win(s_win + ((inc > M32) ? M32 : inc));
  endfunction

  function automatic void shrink_win(logic [63:0] dec);
    set_win((dec >= s_win) ? 64'd0 : s_win - dec);
  endfunction

  function automatic logic [63:0] sat32(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > M32) ? M32 : s;
  endfunction

  function automatic logic quick_adapt(logic [63:0] now);
    logic fired;
    fired = 1'b0;
    if (now >= s_deadline) begin
      if (s_deadline != 0 && s_pending) begin
        s_pending = 1'b0;
        fired = 1'b1;
        s_ign_target = s_win;
        set_win((s_acked * r_qa) >> 8);
        s_ignored = 0;
      end
      s_acked = 0;
      s_deadline = (now + r_target) & M48;
    end
    return fired;
  endfunction

  function automatic logic fast_increase(logic ecn, logic [63:0] rtt);
    logic [63:0] diff;
    diff = (rtt > r_base) ? rtt - r_base : r_base - rtt;
    if (!ecn && (diff << 8) < FAST_TOLERANCE * r_base) begin
      s_fast_bytes = sat32(s_fast_bytes, r_seg);
      if (s_fast_bytes > s_win || s_fast) begin
        grow_win(r_seg);
        s_fast = 1'b1;
      end
    end else begin
      s_fast_bytes = 0;
      s_fast = 1'b0;
    end
    return s_fast;
  endfunction

  function automatic logic [63:0] fairness_inc(logic [63:0] w);
    return (((r_seg * r_seg * r_fair) / w) * REACT_SCALE) >> 16;
  endfunction

  function automatic void rtt_ecn_cases(logic ecn, logic [63:0] rtt);
    logic [63:0] m, t, w, r, bdp, t1, t2, inc, a, b, s, q, d;
    m = r_seg;
    t = r_target;
    w = (s_win != 0) ? s_win : 64'd1;
    r = (rtt != 0) ? rtt : 64'd1;
    bdp = (r_bdp != 0) ? r_bdp : 64'd1;
    if (!ecn && rtt < t) begin
      t1 = ((t - rtt) * r_inc) / r;
      t2 = (m * m) / w;
      if (t1 > (m << 8)) t1 = m << 8;
      inc = (t1 * t2) >> 8;
      if (inc > m) inc = m;
      grow_win((inc * REACT_SCALE) >> 8);
      grow_win(fairness_inc(s_win));
    end else if (ecn && rtt > t) begin
      a = ((rtt - t) * DEC_GAIN_W) / r;
      b = (w * r_dec) / bdp;
      if (a > 256) a = 256;
      if (b > 256) b = 256;
      s = a * m + b * m;
      if (s > (m << 8)) s = m << 8;
      shrink_win((s * REACT_SCALE) >> 16);
    end else if (ecn && rtt < t) begin
      q = (w * r_dec) / bdp;
      if (q > M32) q = M32;
      d = (((q * m) >> 8) * REACT_SCALE) >> 8;
      shrink_win((d > m) ? d : m);
    end else if (!ecn && rtt > t) begin
      grow_win(fairness_inc(w));
    end
  endfunction

  function automatic window_t update_window(cc_event_t ev);
    window_t res;
    logic    fired;
    fired = 1'b0;
    if (ev.kind == decw_pkg::KIND_NACK || ev.kind == decw_pkg::KIND_TIMEOUT) begin
      if (s_ignored >= s_ign_target) begin
        s_pending = 1'b1;
        fired = quick_adapt(64'(ev.now));
      end
    end else if (ev.kind == decw_pkg::KIND_ACK) begin
      s_acked = sat32(s_acked, r_seg);
      if (s_ignored < s_ign_target) begin
        s_ignored = sat32(s_ignored, r_seg);
      end else begin
        fired = quick_adapt(64'(ev.now));
        if (!fired && !fast_increase(ev.ecn, 64'(ev.rtt)))
          rtt_ecn_cases(ev.ecn, 64'(ev.rtt));
      end
    end
    res.win = s_win[31:0];
    res.adapted = fired;
    res.fast = s_fast;
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      decw_pkg::REG_SEG_SIZE:        r_seg = 64'(v[15:0]);
      decw_pkg::REG_TARGET_RTT:      r_target = 64'(v);
      decw_pkg::REG_BASE_RTT:        r_base = 64'(v);
      decw_pkg::REG_PATH_BDP:        r_bdp = 64'(v);
      decw_pkg::REG_QA_SCALE:        r_qa = 64'(v[15:0]);
      decw_pkg::REG_FAIR_GAIN:       r_fair = 64'(v[15:0]);
      decw_pkg::REG_DELAY_INC_GAIN:  r_inc = 64'(v[15:0]);
      decw_pkg::REG_WINDOW_DEC_GAIN: r_dec = 64'(v[15:0]);
      default: ;
    endcase
  endfunction

  function automatic void push_event(logic [1:0] k, logic e, logic [31:0] r, logic [47:0] n);
    cc_event_t ev;
    ev.kind = k;
    ev.ecn = e;
    ev.rtt = r;
    ev.now = n;
    event_queue.push_back(ev);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v < 0) return 32'd0;
    if (v > longint'(M32)) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic cc_event_t random_event();
    cc_event_t ev;
    int unsigned p;
    longint span;
    logic [47:0] noise;
    p = $urandom_range(99);
    ev.kind = (p < 80) ? decw_pkg::KIND_ACK : (p < 88) ? decw_pkg::KIND_NACK :
              (p < 95) ? decw_pkg::KIND_TIMEOUT : decw_pkg::KIND_UNUSED;
    ev.ecn = ($urandom_range(99) < 30);
    case ($urandom_range(9))
      0, 1, 2: begin
        span = longint'(r_base * 12 / 256) + 1;
        ev.rtt = clamp32(longint'(r_base) - span + longint'(64'($urandom) % (2 * span + 1)));
      end
      3, 4: begin
        span = longint'(r_target / 2) + 1;
        ev.rtt = clamp32(longint'(r_target) - span + longint'(64'($urandom) % (2 * span + 1)));
      end
      5: ev.rtt = r_target[31:0];
      6: ev.rtt = r_base[31:0];
      7: ev.rtt = $urandom;
      8: ev.rtt = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: ev.rtt = clamp32(longint'(64'($urandom) % (2 * r_target + 1)));
    endcase
    if ($urandom_range(99) == 0) begin
      noise = 48'({$urandom, $urandom});
      ev.now = noise;
      if (noise > gen_now) gen_now = noise;
    end else begin
      gen_now = gen_now + 48'(64'($urandom) % (r_target / 4 + 1));
      ev.now = gen_now;
    end
    return ev;
  endfunction

  task automatic wait_idle();
    while (event_queue.size() != 0 || in_valid || expected_windows.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] vals[8]);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(3'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_windows.push_back(update_window(on_wire));
      if (!in_valid || in_ready) begin
        if (event_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          on_wire = event_queue.pop_front();
          kind <= on_wire.kind;
          ecn_marked <= on_wire.ecn;
          rtt_ns <= on_wire.rtt;
          now_ns <= on_wire.now;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    window_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          $error("unexpected transaction: window_bytes %0d", window_bytes);
          errors++;
        end else begin
          exp_w = expected_windows.pop_front();
          n_results++;
          if (adapted) n_adapted++;
          if (fast_mode) n_fast++;
          if (window_bytes !== exp_w.win) begin
            $error("window_bytes: expected %0d, got %0d", exp_w.win, window_bytes);
            errors++;
          end
          if (adapted !== exp_w.adapted) begin
            $error("adapted: expected %0d, got %0d", exp_w.adapted, adapted);
            errors++;
          end
          if (fast_mode !== exp_w.fast) begin
            $error("fast_mode: expected %0d, got %0d", exp_w.fast, fast_mode);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d transactions outstanding", expected_windows.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] vals[8];
    r_seg = 4096; r_target = 12000; r_base = 10000; r_bdp = 150000;
    r_qa = 256; r_fair = 256; r_inc = 256; r_dec = 256;
    s_win = 64'(decw_pkg::RST_PATH_BDP);
    s_acked = 0; s_ign_target = 0; s_ignored = 0; s_deadline = 0; s_fast_bytes = 0;
    s_pending = 1'b0; s_fast = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd10000, 48'd0);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd12000, 48'd100);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd0, 48'd200);
    push_event(decw_pkg::KIND_ACK, 1'b1, 32'hFFFF_FFFF, 48'd300);
    push_event(decw_pkg::KIND_ACK, 1'b1, 32'd5000, 48'd400);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd20000, 48'd500);
    push_event(decw_pkg::KIND_ACK, 1'b1, 32'd12000, 48'd600);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd10100, 48'd700);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd10100, 48'd800);
    push_event(decw_pkg::KIND_NACK, 1'b0, 32'd0, 48'd13000);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd10000, 48'd13100);
    push_event(decw_pkg::KIND_ACK, 1'b1, 32'd30000, 48'd13200);
    push_event(decw_pkg::KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_event(decw_pkg::KIND_TIMEOUT, 1'b1, 32'hFFFF_FFFF, 48'd30000);
    push_event(decw_pkg::KIND_TIMEOUT, 1'b0, 32'd0, 48'hFFFF_FFFF_FFFF);
    push_event(decw_pkg::KIND_ACK, 1'b0, 32'd9000, 48'hFFFF_FFFF_FFFF);
    push_event(decw_pkg::KIND_ACK, 1'b1, 32'd0, 48'hFFFF_FFFF_FFFF);
    push_event(decw_pkg::KIND_NACK, 1'b1, 32'hAAAA_5555, 48'h5555_AAAA_5555);
    gen_now = 48'd0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph / 2)
        0: begin send_idle = 8; recv_idle = 60; end
        1: begin send_idle = 60; recv_idle = 8; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: vals = '{32'd1500, 32'd12000, 32'd10000, 32'd150000,
                    32'd200, 32'd300, 32'd400, 32'd500};
        1: vals = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
        2: vals = '{32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'd65535, 32'd65535, 32'd65535, 32'd65535};
        default: begin
          vals[0] = $urandom_range(1, 65535);
          vals[1] = $urandom_range(1000, 2000000);
          vals[2] = vals[1] - vals[1] / $urandom_range(2, 10);
          vals[3] = $urandom_range(1, 32'hFFFF_FFFF);
          for (int i = 4; i < 8; i++) vals[i] = $urandom_range(0, 65535);
        end
      endcase
      @(posedge clk);
      write_regs(vals);
      gen_now = s_deadline[47:0];
      for (int i = 0; i < PHASE_EVENTS; i++) event_queue.push_back(random_event());
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d transactions over 6 register settings and three stall patterns",
             n_results);
    $display("%0d quick adapt resets, %0d results in fast increase", n_adapted, n_fast);
    if (errors == 0 && expected_windows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
